// ----- rtl/core/s2lm_pkg.sv -----
package s2lm_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned CMD_Q_DEPTH = 2;
    localparam int unsigned RES_Q_DEPTH = 4;

    typedef enum logic [1:0] {
        ACT_APPEND_A = 2'd0,
        ACT_APPEND_B = 2'd1,
        ACT_MERGE    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_RUN
    } t_back_state;

    typedef struct packed {
        t_action                    action;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  merged_value;
        logic                       from_list;
        logic                       last;
        logic                       both_empty;
        logic                       overflowed;
    } t_result;

endpackage

// ----- rtl/core/sorted_two_list_merge_core.sv -----
// channel   | direction | handshake          | beat fields
// ----------+-----------+--------------------+--------------------------------------------
// command   | in        | push / full        | i_action, i_value
// result    | out       | pop / empty        | o_merged_value, o_from_list, o_last,
//           |           |                    | o_both_empty, o_overflowed
//
// an append is written by the back end while it is idle; a merge picks up the command, then
// primes the registered list reads, then gives one result per cycle from the compare of the two
// list heads while the result queue is not full; a merge of two empty lists gives a single beat
// reset is synchronous and active low; it empties both queues and both lists at once
// a full result queue stalls the merge in place; the command queue keeps taking beats
// until it fills
module sorted_two_list_merge_core #(
    parameter int unsigned LIST_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_action,
    input  logic signed [31:0] i_value,
    output logic              empty,
    input  logic              pop,
    output logic signed [31:0] o_merged_value,
    output logic              o_from_list,
    output logic              o_last,
    output logic              o_both_empty,
    output logic              o_overflowed
);
    import s2lm_pkg::*;

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    logic    res_push;
    t_result res_in;
    logic    res_full;
    t_result res_out;

    s2lm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    s2lm_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    s2lm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_merged_value = res_out.merged_value;
    assign o_from_list    = res_out.from_list;
    assign o_last         = res_out.last;
    assign o_both_empty   = res_out.both_empty;
    assign o_overflowed   = res_out.overflowed;

endmodule

// ----- rtl/core/s2lm_ram.sv -----
module s2lm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/s2lm_front.sv -----
module s2lm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [1:0]       i_action,
    input  logic signed [31:0] i_value,
    output logic             o_cmd_valid,
    output s2lm_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_pop
);
    import s2lm_pkg::*;

    localparam int unsigned PW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int unsigned CW = $clog2(CMD_Q_DEPTH + 1);

    t_cmd          r_q [CMD_Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          accept;
    logic          known;
    logic          enq;
    logic          deq;

    assign o_full      = (r_cnt == CW'(CMD_Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    assign accept = i_push && !o_full;
    // unused action code is swallowed here and never reaches the back end
    assign known  = i_action inside {ACT_APPEND_A, ACT_APPEND_B, ACT_MERGE};
    assign enq    = accept && known;
    assign deq    = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (enq) begin
            n_wr_ptr = (r_wr_ptr == PW'(CMD_Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (deq) begin
            n_rd_ptr = (r_rd_ptr == PW'(CMD_Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (enq && !deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (deq && !enq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= '{action: t_action'(i_action), value: i_value};
        end
    end

endmodule

// ----- rtl/core/s2lm_outq.sv -----
module s2lm_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  s2lm_pkg::t_result i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output s2lm_pkg::t_result o_data
);
    import s2lm_pkg::*;

    localparam int unsigned PW = (RES_Q_DEPTH > 1) ? $clog2(RES_Q_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RES_Q_DEPTH + 1);

    t_result       r_q [RES_Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          enq;
    logic          deq;

    assign o_full  = (r_cnt == CW'(RES_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rd_ptr];
    assign enq     = i_push && !o_full;
    assign deq     = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (enq) begin
            n_wr_ptr = (r_wr_ptr == PW'(RES_Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (deq) begin
            n_rd_ptr = (r_rd_ptr == PW'(RES_Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (enq && !deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (deq && !enq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/s2lm_back.sv -----
module s2lm_back #(
    parameter int unsigned LIST_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  s2lm_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_push,
    output s2lm_pkg::t_result o_res,
    input  logic              i_res_full
);
    import s2lm_pkg::*;

    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

    t_back_state         r_state, n_state;
    logic [CW-1:0]       r_cnt_a, n_cnt_a;
    logic [CW-1:0]       r_cnt_b, n_cnt_b;
    logic [CW-1:0]       r_ia, n_ia;
    logic [CW-1:0]       r_ib, n_ib;
    logic                r_dropped, n_dropped;

    logic                we_a, we_b;
    logic [VALUE_W-1:0]  rd_a, rd_b;
    logic                a_has, b_has;
    logic                take_a;
    logic                emit;
    logic                done;
    logic                is_append_a, is_append_b, is_merge;

    assign is_append_a = i_cmd_valid && (i_cmd.action == ACT_APPEND_A);
    assign is_append_b = i_cmd_valid && (i_cmd.action == ACT_APPEND_B);
    assign is_merge    = i_cmd_valid && (i_cmd.action == ACT_MERGE);

    // during a merge, read data shows the entry at the current head index
    s2lm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_raddr (n_ia[AW-1:0]),
        .o_rdata (rd_a)
    );

    s2lm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_raddr (n_ib[AW-1:0]),
        .o_rdata (rd_b)
    );

    assign a_has  = (r_ia < r_cnt_a);
    assign b_has  = (r_ib < r_cnt_b);
    // ties go to list a
    assign take_a = a_has && (!b_has || ($signed(rd_a) <= $signed(rd_b)));
    assign emit   = (r_state == ST_RUN) && !i_res_full;
    // nothing left once this beat goes; also covers two empty lists
    assign done   = (n_ia == r_cnt_a) && (n_ib == r_cnt_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (is_merge) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (emit && done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{merged_value: take_a ? rd_a : (b_has ? rd_b : '0),
                       from_list:    !take_a && b_has,
                       last:         done,
                       both_empty:   !a_has && !b_has,
                       overflowed:   r_dropped};
        we_a       = 1'b0;
        we_b       = 1'b0;
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_ia       = r_ia;
        n_ib       = r_ib;
        n_dropped  = r_dropped;
        case (r_state)
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (is_append_a) begin
                    if (r_cnt_a < CW'(LIST_DEPTH)) begin
                        we_a    = 1'b1;
                        n_cnt_a = r_cnt_a + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                if (is_append_b) begin
                    if (r_cnt_b < CW'(LIST_DEPTH)) begin
                        we_b    = 1'b1;
                        n_cnt_b = r_cnt_b + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
            end
            ST_PRIME: begin
                n_ia = r_ia;
            end
            ST_RUN: begin
                if (take_a) begin
                    n_ia = r_ia + 1'b1;
                end else if (b_has) begin
                    n_ib = r_ib + 1'b1;
                end
                if (!emit) begin
                    n_ia = r_ia;
                    n_ib = r_ib;
                end
                o_res_push = emit;
                if (emit && done) begin
                    n_cnt_a   = '0;
                    n_cnt_b   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_ia      <= '0;
            r_ib      <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_a   <= n_cnt_a;
            r_cnt_b   <= n_cnt_b;
            r_dropped <= n_dropped;
            if (emit && done) begin
                r_ia <= '0;
                r_ib <= '0;
            end else begin
                r_ia <= n_ia;
                r_ib <= n_ib;
            end
        end
    end

endmodule

// ----- rtl/core/s2lm_checker.sv -----
module s2lm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic signed [31:0] o_merged_value,
    input logic              o_from_list,
    input logic              o_last,
    input logic              o_both_empty
);

    // both queues come out of reset empty
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // the empty-run beat is a whole run on its own
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_both_empty |-> o_last)
        else $error("empty-run beat without last");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_both_empty |-> (o_merged_value == 32'sd0) && !o_from_list)
        else $error("empty-run beat carries data");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_merged_value) && $stable(o_last))
        else $error("stalled result beat changed");

endmodule

bind sorted_two_list_merge_core s2lm_checker u_s2lm_checker (.*);

// ----- bench/tb.sv -----
module tb;
    import s2lm_pkg::*;

    localparam int         LIST_DEPTH     = 32;
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         RANDOM_ITEMS   = 290;
    localparam int         TOTAL_ITEMS    = 330;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              push     = 1'b0;
    logic              full;
    logic [1:0]        i_action = 2'd0;
    logic signed [31:0] i_value = 32'sd0;
    logic              empty;
    logic              pop      = 1'b0;
    logic signed [31:0] o_merged_value;
    logic              o_from_list;
    logic              o_last;
    logic              o_both_empty;
    logic              o_overflowed;

    sorted_two_list_merge_core #(.LIST_DEPTH(LIST_DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_value        (i_value),
        .empty          (empty),
        .pop            (pop),
        .o_merged_value (o_merged_value),
        .o_from_list    (o_from_list),
        .o_last         (o_last),
        .o_both_empty   (o_both_empty),
        .o_overflowed   (o_overflowed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted list contents and the merged beats still owed by the block
    logic signed [31:0] list_a [LIST_DEPTH];
    logic signed [31:0] list_b [LIST_DEPTH];
    int                 len_a      = 0;
    int                 len_b      = 0;
    bit                 drop_seen  = 1'b0;
    t_result            merged_run_q [$];

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int merges        = 0;
    int drop_merges   = 0;
    int longest_run   = 0;
    bit quiet         = 1'b0;
    bit tx_no_gap     = 1'b0;
    bit hold_req      = 1'b0;

    task automatic predict_beat(input logic [1:0] act, input logic signed [31:0] v);
        int      ia;
        int      ib;
        int      total;
        bit      take_a;
        t_result r;
        case (act)
            ACT_APPEND_A: begin
                if (len_a < LIST_DEPTH) begin
                    list_a[len_a] = v;
                    len_a++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            ACT_APPEND_B: begin
                if (len_b < LIST_DEPTH) begin
                    list_b[len_b] = v;
                    len_b++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            ACT_MERGE: begin
                total = len_a + len_b;
                if (total == 0) begin
                    r.merged_value = 32'sd0;
                    r.from_list    = 1'b0;
                    r.last         = 1'b1;
                    r.both_empty   = 1'b1;
                    r.overflowed   = drop_seen;
                    merged_run_q.push_back(r);
                end else begin
                    ia = 0;
                    ib = 0;
                    while (ia < len_a || ib < len_b) begin
                        if (ia >= len_a)
                            take_a = 1'b0;
                        else if (ib >= len_b)
                            take_a = 1'b1;
                        else
                            take_a = (list_a[ia] <= list_b[ib]);
                        if (take_a) begin
                            r.merged_value = list_a[ia];
                            ia++;
                        end else begin
                            r.merged_value = list_b[ib];
                            ib++;
                        end
                        r.from_list  = !take_a;
                        r.last       = (ia + ib == total);
                        r.both_empty = 1'b0;
                        r.overflowed = drop_seen;
                        merged_run_q.push_back(r);
                    end
                end
                merges++;
                if (drop_seen)
                    drop_merges++;
                if (total > longest_run)
                    longest_run = total;
                len_a     = 0;
                len_b     = 0;
                drop_seen = 1'b0;
            end
            default: ;
        endcase
    endtask

    // one command beat; must be entered right after a rising edge
    task automatic send_item(input logic [1:0] act, input logic signed [31:0] v);
        int gap;
        gap = 0;
        if (!quiet && !tx_no_gap && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_action <= act;
        i_value  <= v;
        do
            @(posedge i_clk);
        while (full);
        if (act != ACT_UNUSED)
            items_sent++;
        predict_beat(act, v);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
            errors++;
        end
    endtask

    // receiver: checks each result beat, idles in bursts, honors long hold-offs
    initial begin
        int      rx_gap;
        int      hold_left;
        t_result want;
        rx_gap    = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (merged_run_q.size() == 0) begin
                    $error("result beat with nothing expected: value 0x%08h", o_merged_value);
                    errors++;
                end else begin
                    want = merged_run_q.pop_front();
                    cmp_field("merged_value", want.merged_value, o_merged_value);
                    cmp_field("from_list", want.from_list, o_from_list);
                    cmp_field("last", want.last, o_last);
                    cmp_field("both_empty", want.both_empty, o_both_empty);
                    cmp_field("overflowed", want.overflowed, o_overflowed);
                    results_seen++;
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 17) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog: cycles in a row with no beat on either side
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic make_list(input int n, input bit ordered, output logic signed [31:0] vals [$]);
        longint cur;
        bit     narrow;
        vals   = {};
        narrow = ($urandom_range(0, 2) == 0);
        if (narrow)
            cur = longint'($urandom_range(0, 8)) - 4;
        else
            cur = longint'($signed($urandom));
        for (int i = 0; i < n; i++) begin
            vals.push_back(cur[31:0]);
            if (!ordered)
                cur = longint'($signed($urandom));
            else if (narrow)
                cur = cur + $urandom_range(0, 2);
            else
                cur = cur + $urandom_range(0, 1 << $urandom_range(0, 27));
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
        end
    endtask

    function automatic int random_len();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10)
            return $urandom_range(0, 5);
        else if (r < 13)
            return $urandom_range(6, 20);
        else if (r < 15)
            return LIST_DEPTH;
        else
            return LIST_DEPTH + $urandom_range(1, 3);
    endfunction

    // loads both lists in a random interleave with stray unused actions, then merges
    task automatic send_sequence(input int la, input int lb, input bit ordered);
        logic signed [31:0] qa [$];
        logic signed [31:0] qb [$];
        bit                 pick_a;
        make_list(la, ordered, qa);
        make_list(lb, ordered, qb);
        while (qa.size() > 0 || qb.size() > 0) begin
            if (!quiet && $urandom_range(0, 19) == 0)
                send_item(ACT_UNUSED, $signed($urandom));
            pick_a = (qb.size() == 0) || (qa.size() > 0 && $urandom_range(0, 1) == 1);
            if (pick_a)
                send_item(ACT_APPEND_A, qa.pop_front());
            else
                send_item(ACT_APPEND_B, qb.pop_front());
        end
        send_item(ACT_MERGE, $signed($urandom));
    endtask

    task automatic test_empty_merge();
        send_item(ACT_MERGE, 32'sd0);
        send_item(ACT_MERGE, -32'sd1);
    endtask

    task automatic test_unused_action();
        send_item(ACT_UNUSED, 32'sh7fff_ffff);
        send_item(ACT_APPEND_A, 32'sd9);
        send_item(ACT_UNUSED, -32'sd1);
        send_item(ACT_MERGE, 32'sd0);
    endtask

    task automatic test_extremes_and_ties();
        send_item(ACT_APPEND_A, 32'sh8000_0000);
        send_item(ACT_APPEND_A, 32'sd0);
        send_item(ACT_APPEND_A, 32'sd0);
        send_item(ACT_APPEND_A, 32'sh7fff_ffff);
        send_item(ACT_APPEND_B, 32'sh8000_0000);
        send_item(ACT_APPEND_B, 32'sd0);
        send_item(ACT_APPEND_B, 32'sh7fff_ffff);
        send_item(ACT_MERGE, 32'sh5555_5555);
    endtask

    task automatic test_one_sided();
        send_item(ACT_APPEND_A, -32'sd5);
        send_item(ACT_MERGE, 32'sd0);
        send_item(ACT_APPEND_B, 32'sd7);
        send_item(ACT_APPEND_B, 32'sd7);
        send_item(ACT_MERGE, 32'shaaaa_aaaa);
    endtask

    // receiver holds off while long lists load, so the result side backs up into full
    task automatic test_backpressure();
        tx_no_gap = 1'b1;
        hold_req  = 1'b1;
        send_sequence(24, 24, 1'b1);
        send_sequence(3, 3, 1'b1);
        tx_no_gap = 1'b0;
    endtask

    task automatic test_random_runs();
        while (items_sent < RANDOM_ITEMS)
            send_sequence(random_len(), random_len(), $urandom_range(0, 4) != 0);
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        while (items_sent < TOTAL_ITEMS)
            send_sequence($urandom_range(0, 8), $urandom_range(0, 8), 1'b1);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_merge();
        test_unused_action();
        test_extremes_and_ties();
        test_one_sided();
        test_backpressure();
        test_random_runs();
        test_quiet_tail();
        push <= 1'b0;
        while (merged_run_q.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        $display("sent %0d command beats: %0d merges, %0d of them after dropped appends",
                 items_sent, merges, drop_merges);
        $display("checked %0d result beats, longest merged run %0d", results_seen, longest_run);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
